[src/row_peak_center_finder_core_assert.svh]
// assertion macros shared by the row peak centre finder checkers
`ifndef ROW_PEAK_CENTER_FINDER_CORE_ASSERT_SVH
`define ROW_PEAK_CENTER_FINDER_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is asserted
`define RPCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RPCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rpcf_pkg.sv]
// shared types and constants of the row peak centre finder
package rpcf_pkg;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int SUM_W   = 22;
  localparam int CNT_W   = 12;
  localparam int STEP_W  = 5;

  localparam int COL_MAX        = 2047;
  localparam int ROW_WIDTH_DEF  = 2048;

  localparam logic [PIX_W-1:0]  THRESH_RESET = 8'd100;
  localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

  // one quotient bit per divider step
  localparam logic [STEP_W-1:0] DIV_LAST     = STEP_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

[src/rpcf_in_if.sv]
// sample channel: pixel value and end-of-row flag
interface rpcf_in_if;
  logic                       valid;
  logic                       ready;
  logic [rpcf_pkg::PIX_W-1:0] pixel_value;
  logic                       last_in_row;

  modport source (output valid, output pixel_value, output last_in_row, input ready);
  modport sink   (input valid, input pixel_value, input last_in_row, output ready);
endinterface

[src/rpcf_out_if.sv]
// result channel: peak column and found flag
interface rpcf_out_if;
  logic                       valid;
  logic                       ready;
  logic [rpcf_pkg::COL_W-1:0] peak_column;
  logic                       peak_found;

  modport source (output valid, output peak_column, output peak_found, input ready);
  modport sink   (input valid, input peak_column, input peak_found, output ready);
endinterface

[src/rpcf_cfg_if.sv]
// configuration write channel carrying the peak threshold
interface rpcf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rpcf_pkg::PIX_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/row_peak_center_finder_core.sv]
// row peak centre finder: per-row brightest-column mean with an iterative divider
//
// in_bus carries one beat per sample: pixel_value and last_in_row. samples of a row
// are taken one per cycle; each beat updates the running maximum and the sum and
// count of the columns that hold it, all in the cycle it is accepted.
// the beat flagged last_in_row closes the row: the sum and count are handed to a
// restoring divider that yields one quotient bit per cycle, then a hand-over
// state loads the output register once it is free. in_bus.ready is low through
// the division and the hand-over, so the next row waits until both are done.
// out_bus gives one beat per row, after that division and hand-over:
// peak_column is the floor of the mean column when the maximum beats the
// threshold, else 0 with peak_found clear.
// if the receiver stalls, the result sits in the output register and the next
// row is still taken; a further row end waits after its division until the
// register is free.
// cfg_bus writes peak_threshold at any beat; it is always ready.
// reset (rst_n low, synchronous) clears the row state, empties the output and
// sets the threshold to 100.
module row_peak_center_finder_core #(
  parameter int ROW_WIDTH = rpcf_pkg::ROW_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rpcf_in_if.sink      in_bus,
  rpcf_out_if.source   out_bus,
  rpcf_cfg_if.sink     cfg_bus
);

  // last column the index may reach, capped by the field width
  localparam int LAST_COL_I = (ROW_WIDTH - 1 > rpcf_pkg::COL_MAX) ?
                              rpcf_pkg::COL_MAX : ROW_WIDTH - 1;
  localparam logic [rpcf_pkg::COL_W-1:0] LAST_COL = LAST_COL_I[rpcf_pkg::COL_W-1:0];

  rpcf_pkg::state_t state_r, state_nxt;

  // row accumulation state
  logic [rpcf_pkg::COL_W-1:0]  col_r,  col_nxt;
  logic [rpcf_pkg::PIX_W-1:0]  max_r,  max_nxt;
  logic [rpcf_pkg::SUM_W-1:0]  sum_r,  sum_nxt;
  logic [rpcf_pkg::CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [rpcf_pkg::PIX_W-1:0]  thresh_r, thresh_nxt;

  // divider state: dividend shifts out as the quotient shifts in
  logic [rpcf_pkg::SUM_W-1:0]  dq_r,   dq_nxt;
  logic [rpcf_pkg::CNT_W-1:0]  rem_r,  rem_nxt;
  logic [rpcf_pkg::CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic                        found_r, found_nxt;
  logic [rpcf_pkg::STEP_W-1:0] step_r, step_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [rpcf_pkg::COL_W-1:0]  out_col_r,   out_col_nxt;
  logic                        out_found_r, out_found_nxt;

  // sequencer outputs
  logic in_ready;
  logic div_run;
  logic out_load;
  logic out_free;

  logic                        in_acc;
  logic                        px_gt;
  logic                        px_eq;
  logic [rpcf_pkg::SUM_W:0]    sum_add;
  logic [rpcf_pkg::SUM_W-1:0]  sum_sat;
  logic [rpcf_pkg::PIX_W-1:0]  max_upd;
  logic [rpcf_pkg::SUM_W-1:0]  sum_upd;
  logic [rpcf_pkg::CNT_W-1:0]  cnt_upd;
  logic [rpcf_pkg::CNT_W:0]    div_sh;
  logic                        div_ge;
  logic [rpcf_pkg::CNT_W:0]    div_diff;

  assign in_acc   = in_bus.valid && in_ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready        = in_ready;
  assign cfg_bus.ready       = 1'b1;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.peak_column = out_col_r;
  assign out_bus.peak_found  = out_found_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpcf_pkg::ST_ACC: begin
        if (in_acc && in_bus.last_in_row) begin
          state_nxt = rpcf_pkg::ST_DIV;
        end
      end
      rpcf_pkg::ST_DIV: begin
        if (step_r == rpcf_pkg::DIV_LAST) begin
          state_nxt = rpcf_pkg::ST_HOLD;
        end
      end
      rpcf_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = rpcf_pkg::ST_ACC;
        end
      end
      default: state_nxt = rpcf_pkg::ST_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      rpcf_pkg::ST_ACC:  in_ready = 1'b1;
      rpcf_pkg::ST_DIV:  div_run  = 1'b1;
      rpcf_pkg::ST_HOLD: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // per-sample update of maximum, column sum and count
  always_comb begin
    px_gt   = in_bus.pixel_value > max_r;
    px_eq   = (in_bus.pixel_value == max_r) && (cnt_r < rpcf_pkg::CNT_MAX);
    sum_add = {1'b0, sum_r} + {{(rpcf_pkg::SUM_W + 1 - rpcf_pkg::COL_W){1'b0}}, col_r};
    sum_sat = sum_add[rpcf_pkg::SUM_W] ? rpcf_pkg::SUM_MAX : sum_add[rpcf_pkg::SUM_W-1:0];

    max_upd = max_r;
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    priority if (px_gt) begin
      max_upd = in_bus.pixel_value;
      sum_upd = {{(rpcf_pkg::SUM_W - rpcf_pkg::COL_W){1'b0}}, col_r};
      cnt_upd = rpcf_pkg::CNT_W'(1);
    end else if (px_eq) begin
      sum_upd = sum_sat;
      cnt_upd = cnt_r + rpcf_pkg::CNT_W'(1);
    end
  end

  // one restoring division step
  always_comb begin
    div_sh   = {rem_r, dq_r[rpcf_pkg::SUM_W-1]};
    div_diff = div_sh - {1'b0, dcnt_r};
    div_ge   = div_sh >= {1'b0, dcnt_r};
  end

  // datapath next values
  always_comb begin
    col_nxt       = col_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    thresh_nxt    = thresh_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    found_nxt     = found_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_found_nxt = out_found_r;

    if (cfg_bus.valid) begin
      thresh_nxt = cfg_bus.data;
    end

    if (in_acc) begin
      if (in_bus.last_in_row) begin
        // close the row and load the divider
        col_nxt   = '0;
        max_nxt   = '0;
        sum_nxt   = '0;
        cnt_nxt   = '0;
        dq_nxt    = sum_upd;
        rem_nxt   = '0;
        dcnt_nxt  = cnt_upd;
        found_nxt = max_upd > thresh_r;
        step_nxt  = '0;
      end else begin
        col_nxt = (col_r < LAST_COL) ? col_r + rpcf_pkg::COL_W'(1) : col_r;
        max_nxt = max_upd;
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end

    if (div_run) begin
      rem_nxt  = div_ge ? div_diff[rpcf_pkg::CNT_W-1:0] : div_sh[rpcf_pkg::CNT_W-1:0];
      dq_nxt   = {dq_r[rpcf_pkg::SUM_W-2:0], div_ge};
      step_nxt = step_r + rpcf_pkg::STEP_W'(1);
    end

    // quotient never exceeds the largest column, so its low bits are the mean
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
      out_col_nxt   = (found_r && (dcnt_r != '0)) ? dq_r[rpcf_pkg::COL_W-1:0] : '0;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpcf_pkg::ST_ACC;
      out_valid_r <= 1'b0;
      thresh_r    <= rpcf_pkg::THRESH_RESET;
      col_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      thresh_r    <= thresh_nxt;
      col_r       <= col_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    found_r     <= found_nxt;
    out_col_r   <= out_col_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule

[src/rpcf_checker.sv]
// port-level checks of the row peak centre finder, bound to the top level
`include "row_peak_center_finder_core_assert.svh"

module rpcf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last_in_row,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rpcf_pkg::COL_W-1:0] out_peak_column,
  input logic                       out_peak_found
);

  // a stalled result beat holds
  `RPCF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_peak_column) && $stable(out_peak_found), "result beat changed while stalled")

  // no peak means column zero
  `RPCF_ASSERT(a_not_found_zero, out_valid && !out_peak_found |-> out_peak_column == '0, "column not zero without a peak")

  // row end starts the divider, which blocks the sample channel
  `RPCF_ASSERT(a_busy_after_row, in_valid && in_ready && in_last_in_row |=> !in_ready, "sample taken while divider busy")

  // a fresh result only leaves the divider hand-over
  `RPCF_ASSERT(a_result_from_div, $rose(out_valid) |-> $past(!in_ready), "result appeared without a division")

  // reset empties the output register
  `RPCF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output not empty after reset")

endmodule

bind row_peak_center_finder_core rpcf_checker u_rpcf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_last_in_row  (in_bus.last_in_row),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_peak_column (out_bus.peak_column),
  .out_peak_found  (out_bus.peak_found)
);

[bench/testbench.sv]
// self-checking bench for the row peak centre finder: directed and random rows against an in-bench predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W = rpcf_pkg::PIX_W;
  localparam int COL_W = rpcf_pkg::COL_W;
  localparam int SUM_W = rpcf_pkg::SUM_W;
  localparam int CNT_W = rpcf_pkg::CNT_W;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int ROW_W         = rpcf_pkg::ROW_WIDTH_DEF;
  // the column counter pins at the last column of the row or of the field
  localparam int LAST_COL      = (ROW_W - 1 > rpcf_pkg::COL_MAX) ? rpcf_pkg::COL_MAX : ROW_W - 1;
  // covers the divider and the hand-over, with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_GAP       = 15;
  // limit for the watchdog, well above the slowest correct run
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BEATS  = 170;

  // one sample beat waiting to be driven, with the idle cycles that go before it
  typedef struct {
    logic [PIX_W-1:0] value;
    logic             last;
    int               gap;
  } pixel_beat_t;

  // what a closed row should report
  typedef struct {
    logic [COL_W-1:0] column;
    logic             found;
  } row_peak_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rpcf_in_if  in_bus();
  rpcf_out_if out_bus();
  rpcf_cfg_if cfg_bus();

  // everything driven into the block, known from time zero
  logic             px_valid  = 1'b0;
  logic [PIX_W-1:0] px_value  = '0;
  logic             px_last   = 1'b0;
  logic             res_ready = 1'b0;
  logic             thr_valid = 1'b0;
  logic [PIX_W-1:0] thr_data  = '0;

  assign in_bus.valid       = px_valid;
  assign in_bus.pixel_value = px_value;
  assign in_bus.last_in_row = px_last;
  assign out_bus.ready      = res_ready;
  assign cfg_bus.valid      = thr_valid;
  assign cfg_bus.data       = thr_data;

  row_peak_center_finder_core #(
    .ROW_WIDTH(ROW_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: threshold and the row accumulator, all at the block's widths
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] thr_model = rpcf_pkg::THRESH_RESET;
  logic [COL_W-1:0] col_model = '0;
  logic [PIX_W-1:0] max_model = '0;
  logic [SUM_W-1:0] sum_model = '0;
  logic [CNT_W-1:0] cnt_model = '0;

  pixel_beat_t pixel_queue[$];
  row_peak_t   expected_peaks[$];

  logic feed_calm    = 1'b0;
  int   beats_queued = 0;
  int   beats_in     = 0;
  int   rows_out     = 0;
  int   peaks_out    = 0;
  int   thr_writes   = 0;
  int   fails        = 0;

  // fold one accepted sample into the row; a row end queues its expected report
  task automatic predict_pixel(input logic [PIX_W-1:0] value, input logic last);
    logic [SUM_W:0]   sum_next;
    logic [SUM_W-1:0] quotient;
    row_peak_t        peak;
    if (value > max_model) begin
      // new brightest level restarts the column mean here
      max_model = value;
      sum_model = col_model;
      cnt_model = 1;
    end else if (value == max_model && cnt_model != rpcf_pkg::CNT_MAX) begin
      // tie with the maximum: sum saturates, count stops once full
      sum_next  = sum_model + col_model;
      sum_model = (sum_next > rpcf_pkg::SUM_MAX) ? rpcf_pkg::SUM_MAX : sum_next[SUM_W-1:0];
      cnt_model = cnt_model + 1'b1;
    end
    if (col_model < COL_W'(LAST_COL)) col_model = col_model + 1'b1;
    if (last) begin
      peak.found = max_model > thr_model;
      quotient   = '0;
      if (peak.found && cnt_model != '0) quotient = sum_model / cnt_model;
      peak.column = quotient[COL_W-1:0];
      expected_peaks.push_back(peak);
      col_model = '0;
      max_model = '0;
      sum_model = '0;
      cnt_model = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, then tracks threshold writes and sample beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    row_peak_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        rows_out++;
        if (expected_peaks.size() == 0) begin
          $error("result beat with no row pending: peak_column %0d, peak_found %0b",
                 out_bus.peak_column, out_bus.peak_found);
          fails++;
        end else begin
          want = expected_peaks.pop_front();
          if (out_bus.peak_column !== want.column) begin
            $error("peak_column: expected %0d, got %0d", want.column, out_bus.peak_column);
            fails++;
          end
          if (out_bus.peak_found !== want.found) begin
            $error("peak_found: expected %0b, got %0b", want.found, out_bus.peak_found);
            fails++;
          end
          if (want.found) peaks_out++;
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) thr_model = cfg_bus.data;
      if (in_bus.valid && in_bus.ready) begin
        predict_pixel(in_bus.pixel_value, in_bus.last_in_row);
        beats_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample driver: idles for each beat's gap, then holds the beat until taken
  // ---------------------------------------------------------------------------
  int   in_hold   = 0;
  logic gap_taken = 1'b0;

  always @(posedge clk) begin
    pixel_beat_t beat;
    if (!rst_n) begin
      px_valid  <= 1'b0;
      in_hold   <= 0;
      gap_taken <= 1'b0;
    end else if (!px_valid || in_bus.ready) begin
      if (in_hold > 0) begin
        px_valid <= 1'b0;
        in_hold  <= in_hold - 1;
      end else if (pixel_queue.size() == 0) begin
        px_valid <= 1'b0;
      end else if (pixel_queue[0].gap > 0 && !gap_taken) begin
        px_valid  <= 1'b0;
        in_hold   <= pixel_queue[0].gap - 1;
        gap_taken <= 1'b1;
      end else begin
        beat = pixel_queue.pop_front();
        px_valid  <= 1'b1;
        px_value  <= beat.value;
        px_last   <= beat.last;
        gap_taken <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: stalls a random while after each beat, with calm stretches
  // ---------------------------------------------------------------------------
  int   res_hold = 0;
  logic res_calm = 1'b0;

  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      res_ready <= 1'b0;
      res_hold  <= 0;
    end else if (out_bus.valid && res_ready) begin
      if ($urandom_range(0, 15) == 0) res_calm <= !res_calm;
      stall = res_calm ? 0 : int'($urandom_range(0, MAX_GAP));
      res_ready <= (stall == 0);
      res_hold  <= stall;
    end else if (res_hold > 0) begin
      res_hold  <= res_hold - 1;
      res_ready <= (res_hold == 1);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still pending",
               cycle_count, expected_peaks.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pixel(input logic [PIX_W-1:0] value, input logic last);
    pixel_beat_t beat;
    beat.value = value;
    beat.last  = last;
    beat.gap   = feed_calm ? 0 : int'($urandom_range(0, MAX_GAP));
    pixel_queue.push_back(beat);
    beats_queued++;
  endtask

  // mostly short rows so many row ends, divisions and thresholds get exercised
  task automatic queue_random_row();
    int               len;
    int               shape;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] value;
    shape = $urandom_range(0, 9);
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 300) : $urandom_range(1, 16);
    hi    = PIX_W'($urandom);
    lo    = PIX_W'($urandom);
    if ($urandom_range(0, 7) == 0) feed_calm = !feed_calm;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0, 1, 2, 3: value = PIX_W'($urandom);
        // two levels, so lots of ties at the maximum
        4, 5, 6: value = ($urandom_range(0, 1) == 1) ? hi : lo;
        // regular plateau spaced through the row
        7: value = (i % 5 == 2) ? hi : (hi >> 1);
        // dark row, rarely over the threshold
        8: value = PIX_W'($urandom_range(0, 3));
        // near full scale
        default: value = PIX_W'(255 - $urandom_range(0, 2));
      endcase
      queue_pixel(value, i == len - 1);
    end
  endtask

  task automatic queue_random_rows(input int beats);
    int target;
    target = beats_queued + beats;
    while (beats_queued < target) queue_random_row();
  endtask

  // wait for every beat to go in and every report to come out, then let it settle
  task automatic drain();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || px_valid || expected_peaks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [PIX_W-1:0] value);
    @(posedge clk);
    thr_valid <= 1'b1;
    thr_data  <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    thr_valid <= 1'b0;
    thr_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [PIX_W-1:0] thr;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // threshold at its reset value of 100
    @(negedge clk);
    queue_pixel(8'd255, 1'b1);                       // full scale, single-sample row
    queue_pixel(8'd0, 1'b1);                         // dark single sample
    queue_pixel(8'd100, 1'b1);                       // equal to threshold: not reported
    queue_pixel(8'd101, 1'b1);                       // just above it
    repeat (3) queue_pixel(8'd0, 1'b0);              // all-zero row counts every column
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd5, 1'b0);                         // ties at columns 1, 3 and 4
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd7, 1'b0);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd200, 1'b1);
    queue_pixel(8'd150, 1'b0);                       // new maximum restarts the mean
    queue_pixel(8'd150, 1'b0);
    queue_pixel(8'd180, 1'b0);
    queue_pixel(8'd90, 1'b0);
    queue_pixel(8'd180, 1'b1);
    queue_pixel(8'd254, 1'b0);
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd170, 1'b0);                       // alternating bit patterns
    queue_pixel(8'd85, 1'b1);
    drain();

    // lowest threshold: anything but an all-zero row is reported
    write_threshold(8'd0);
    @(negedge clk);
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd1, 1'b1);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd1, 1'b1);
    queue_random_rows(RANDOM_BEATS);
    drain();

    // highest threshold: nothing can ever be reported
    write_threshold(8'd255);
    @(negedge clk);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b1);
    queue_random_rows(RANDOM_BEATS);
    drain();

    // near the extremes, then random settings
    for (int k = 0; k < 4; k++) begin
      if (k == 0) thr = 8'd1;
      else if (k == 1) thr = 8'd254;
      else thr = PIX_W'($urandom);
      write_threshold(thr);
      @(negedge clk);
      queue_random_rows(RANDOM_BEATS);
      drain();
    end

    $display("covered %0d sample beats over %0d rows, %0d of them with a peak reported",
             beats_in, rows_out, peaks_out);
    $display("threshold written %0d times from 0 to 255; rows of 1 up to 300 samples",
             thr_writes);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
